// ===== src/stt_pkg.sv =====
// Shared types, token codes and character-class helpers for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  // Largest value a span offset or length can carry
  localparam logic [23:0] SPAN_MAX = 24'hFFFFFF;
  localparam int unsigned OFFSET_BITS_DEF = 24;

  // Token kinds
  localparam logic [5:0] K_EOF = 6'd0, K_ERROR = 6'd1, K_SYMBOL = 6'd2, K_LBRACE = 6'd3,
    K_RBRACE = 6'd4, K_LPAREN = 6'd5, K_RPAREN = 6'd6, K_LBRACK = 6'd7, K_RBRACK = 6'd8,
    K_QUEST = 6'd9, K_COLON = 6'd10, K_SEMI = 6'd11, K_COMMA = 6'd12, K_DOT = 6'd13,
    K_DOLLAR = 6'd14, K_ASSIGN = 6'd15, K_PLUS = 6'd16, K_MINUS = 6'd17, K_STAR = 6'd18,
    K_SLASH = 6'd19, K_PERCENT = 6'd20, K_PLUS_EQ = 6'd21, K_MINUS_EQ = 6'd22,
    K_STAR_EQ = 6'd23, K_SLASH_EQ = 6'd24, K_EQ = 6'd25, K_NE = 6'd26, K_LT = 6'd27,
    K_GT = 6'd28, K_LE = 6'd29, K_GE = 6'd30, K_LAND = 6'd31, K_LOR = 6'd32, K_NOT = 6'd33,
    K_AND = 6'd34, K_OR = 6'd35, K_XOR = 6'd36, K_TILDE = 6'd37;

  // Symbol classes
  localparam logic [2:0] C_NONE = 3'd0, C_IDENT = 3'd1, C_NUMBER = 3'd2, C_STRING = 3'd3,
    C_KEYWORD = 3'd4;

  // Error codes
  localparam logic [1:0] E_NONE = 2'd0, E_STRING = 2'd1, E_COMMENT = 2'd2, E_BYTE = 2'd3;

  localparam logic [3:0] KW_NONE = 4'd0;
  localparam int unsigned KW_TRUE = 14;

  // Keyword text, first character in the low byte, zero padded
  localparam logic [63:0] KW_TEXT [16] = '{
    64'h7361, 64'h6b61657262, 64'h65736163, 64'h65756e69746e6f63, 64'h746c7561666564,
    64'h6f64, 64'h65736c65, 64'h726f66, 64'h6669, 64'h6e7275746572, 64'h666c6573,
    64'h686374697773, 64'h726176, 64'h656c696877, 64'h65757274, 64'h65736c6166
  };

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_ZERO, M_INT, M_DOT_NUM, M_FRAC, M_HEX, M_BIN, M_OCT,
    M_DOT_WAIT, M_OP_WAIT, M_LINE, M_BLOCK, M_BLOCK_STAR, M_STRING
  } scan_mode_e;

  // One result as it leaves the block
  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  cls;
    logic [3:0]  kw;
    logic [1:0]  err;
    logic [23:0] off;
    logic [23:0] len;
    logic        last;
  } res_t;

  // Outcome of starting a new token on one byte
  typedef struct packed {
    scan_mode_e mode;
    logic       emit;
    logic [5:0] kind;
    logic [1:0] err;
  } fresh_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_xdigit(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_suffix(input logic [7:0] b);
    return b == "f" || b == "F" || b == "d" || b == "D";
  endfunction

  function automatic logic is_op_start(input logic [7:0] b);
    return b == "=" || b == "!" || b == "<" || b == ">" || b == "+" || b == "-" ||
           b == "*" || b == "&" || b == "|" || b == "/";
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      "{": k = K_LBRACE;   "}": k = K_RBRACE;  "(": k = K_LPAREN; ")": k = K_RPAREN;
      "[": k = K_LBRACK;   "]": k = K_RBRACK;  "?": k = K_QUEST;  ":": k = K_COLON;
      ";": k = K_SEMI;     ",": k = K_COMMA;   "$": k = K_DOLLAR; "~": k = K_TILDE;
      "^": k = K_XOR;      "%": k = K_PERCENT;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_one(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "=": k = K_ASSIGN; "!": k = K_NOT;   "<": k = K_LT;    ">": k = K_GT;
      "+": k = K_PLUS;   "-": k = K_MINUS; "*": k = K_STAR;  "&": k = K_AND;
      "|": k = K_OR;
      default: k = K_SLASH;
    endcase
    return k;
  endfunction

  // Two-character operator, K_EOF when the pair is not one
  function automatic logic [5:0] op_two(input logic [7:0] c, input logic [7:0] b);
    logic [5:0] k;
    k = K_EOF;
    if (c == "&") begin
      k = (b == "&") ? K_LAND : K_EOF;
    end else if (c == "|") begin
      k = (b == "|") ? K_LOR : K_EOF;
    end else if (b == "=") begin
      case (c)
        "=": k = K_EQ;      "!": k = K_NE;       "<": k = K_LE;      ">": k = K_GE;
        "+": k = K_PLUS_EQ; "-": k = K_MINUS_EQ; "*": k = K_STAR_EQ;
        default: k = K_SLASH_EQ;
      endcase
    end
    return k;
  endfunction

  function automatic fresh_t fresh_f(input logic [7:0] b);
    fresh_t f;
    f.mode = M_IDLE;
    f.emit = 1'b0;
    f.kind = K_EOF;
    f.err  = E_NONE;
    if (is_space(b)) begin
      f.mode = M_IDLE;
    end else if (is_alpha(b) || b == "_") begin
      f.mode = M_IDENT;
    end else if (is_digit(b)) begin
      f.mode = (b == "0") ? M_ZERO : M_INT;
    end else if (b == ".") begin
      f.mode = M_DOT_WAIT;
    end else if (b == "\"") begin
      f.mode = M_STRING;
    end else if (single_kind(b) != K_EOF) begin
      f.emit = 1'b1;
      f.kind = single_kind(b);
    end else if (is_op_start(b)) begin
      f.mode = M_OP_WAIT;
    end else begin
      f.emit = 1'b1;
      f.kind = K_ERROR;
      f.err  = E_BYTE;
    end
    return f;
  endfunction

endpackage

// ===== src/source_text_tokenizer.sv =====
// Streaming lexical tokenizer: one source byte per request, up to three tokens out.
//
//   channel | signals                          | carries
//   --------+----------------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o          | byte_in_i, end_flag_i
//   out     | out_valid_o / out_ready_i        | token fields, span, last_of_run_o
//
// A byte is scanned in the cycle it is taken; its tokens land in a three-entry result
// buffer and leave one per cycle unless the output stalls. A byte that completes at most
// one token does not hold the input, so plain text goes at one byte per cycle while the
// output flows; a byte that completes more tokens holds the input while the buffer
// drains. Reset is asynchronous and returns the scanner to idle at offset zero.
// Stalls hold the buffer; input is taken when it is empty or its last entry is leaving.
`timescale 1ns / 1ps

module source_text_tokenizer #(
  parameter int unsigned OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_flag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [2:0]  symbol_class_o,
  output logic [3:0]  keyword_index_o,
  output logic [1:0]  error_code_o,
  output logic [23:0] span_offset_o,
  output logic [23:0] span_length_o,
  output logic        last_of_run_o
);
  import stt_pkg::*;

  localparam int unsigned OW = OFFSET_BITS;
  localparam logic [OW-1:0] POS_MAX = '1;

  // Scanner state
  scan_mode_e    mode_q, mode_d;
  logic [OW-1:0] pos_q, pos_d;
  logic [OW-1:0] start_q, start_d;
  logic [OW-1:0] dot_q, dot_d;
  logic [63:0]   prefix_q, prefix_d;
  logic [3:0]    wlen_q, wlen_d;
  logic [7:0]    pend_q, pend_d;

  // Result buffer
  res_t       buf_q [3];
  res_t       res_w [3];
  logic [1:0] cnt_q;
  logic [1:0] n_w;

  logic       in_take, out_take;
  logic [7:0] b;
  logic [OW-1:0] pos_inc;
  fresh_t     fr;

  assign b        = byte_in_i;
  assign pos_inc  = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
  assign fr       = fresh_f(b);
  assign out_take = out_valid_o && out_ready_i;
  assign in_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign in_take  = in_valid_i && in_ready_o;

  function automatic logic [23:0] clamp(input logic [OW-1:0] v);
    return (32'(v) > 32'(SPAN_MAX)) ? SPAN_MAX : 24'(32'(v));
  endfunction

  function automatic res_t mk(input logic [5:0] kind, input logic [2:0] cls,
                              input logic [3:0] kw, input logic [1:0] err,
                              input logic [OW-1:0] s, input logic [OW-1:0] e);
    res_t r;
    r.kind = kind;
    r.cls  = cls;
    r.kw   = kw;
    r.err  = err;
    r.off  = clamp(s);
    r.len  = (e >= s) ? clamp(e - s) : 24'd0;
    r.last = 1'b0;
    return r;
  endfunction

  // Word token: keyword, true/false as numbers, otherwise identifier
  function automatic res_t word_res(input logic [OW-1:0] s, input logic [OW-1:0] e,
                                    input logic [63:0] pfx, input logic [3:0] wl);
    res_t r;
    r = mk(K_SYMBOL, C_IDENT, KW_NONE, E_NONE, s, e);
    if (wl <= 4'd8) begin
      for (int i = 0; i < 16; i++) begin
        if (pfx == KW_TEXT[i] && r.cls == C_IDENT) begin
          if (i >= KW_TRUE) begin
            r.cls = C_NUMBER;
          end else begin
            r.cls = C_KEYWORD;
            r.kw  = 4'(i);
          end
        end
      end
    end
    return r;
  endfunction

  // Number mode ends on this byte
  function automatic logic num_ends(input scan_mode_e m, input logic [7:0] c);
    logic r;
    case (m)
      M_ZERO:  r = !(c == "x" || c == "X" || c == "b" || c == "B" || c == "o" ||
                     c == "O" || is_digit(c) || c == ".");
      M_INT:   r = !(is_digit(c) || c == ".");
      M_FRAC:  r = !is_digit(c);
      M_HEX:   r = !is_xdigit(c);
      M_BIN:   r = !(c == "0" || c == "1");
      M_OCT:   r = (c < "0" || c > "7");
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Results of one request, in order
  always_comb begin
    logic do_fresh;
    logic [5:0] k2;
    n_w = 2'd0;
    do_fresh = 1'b0;
    k2 = op_two(pend_q, b);
    for (int i = 0; i < 3; i++) res_w[i] = '0;
    if (end_flag_i) begin
      case (mode_q)
        M_IDENT: begin
          res_w[n_w] = word_res(start_q, pos_q, prefix_q, wlen_q); n_w = n_w + 2'd1;
        end
        M_ZERO, M_INT, M_FRAC, M_HEX, M_BIN, M_OCT: begin
          res_w[n_w] = mk(K_SYMBOL, C_NUMBER, KW_NONE, E_NONE, start_q, pos_q);
          n_w = n_w + 2'd1;
        end
        M_DOT_NUM: begin
          res_w[n_w] = mk(K_SYMBOL, C_NUMBER, KW_NONE, E_NONE, start_q, dot_q);
          n_w = n_w + 2'd1;
          res_w[n_w] = mk(K_DOT, C_NONE, KW_NONE, E_NONE, dot_q, pos_q); n_w = n_w + 2'd1;
        end
        M_DOT_WAIT: begin
          res_w[n_w] = mk(K_DOT, C_NONE, KW_NONE, E_NONE, start_q, pos_q); n_w = n_w + 2'd1;
        end
        M_OP_WAIT: begin
          res_w[n_w] = mk(op_one(pend_q), C_NONE, KW_NONE, E_NONE, start_q, pos_q);
          n_w = n_w + 2'd1;
        end
        M_BLOCK, M_BLOCK_STAR: begin
          res_w[n_w] = mk(K_ERROR, C_NONE, KW_NONE, E_COMMENT, start_q, pos_q);
          n_w = n_w + 2'd1;
        end
        M_STRING: begin
          res_w[n_w] = mk(K_ERROR, C_NONE, KW_NONE, E_STRING, start_q, pos_q);
          n_w = n_w + 2'd1;
        end
        default: ;
      endcase
      res_w[n_w] = mk(K_EOF, C_NONE, KW_NONE, E_NONE, pos_q, pos_q);
      n_w = n_w + 2'd1;
    end else begin
      case (mode_q)
        M_IDENT: begin
          if (!is_word(b)) begin
            res_w[n_w] = word_res(start_q, pos_q, prefix_q, wlen_q); n_w = n_w + 2'd1;
            do_fresh = 1'b1;
          end
        end
        M_ZERO, M_INT, M_FRAC, M_HEX, M_BIN, M_OCT: begin
          if (num_ends(mode_q, b)) begin
            if (is_suffix(b)) begin
              res_w[n_w] = mk(K_SYMBOL, C_NUMBER, KW_NONE, E_NONE, start_q, pos_inc);
              n_w = n_w + 2'd1;
            end else begin
              res_w[n_w] = mk(K_SYMBOL, C_NUMBER, KW_NONE, E_NONE, start_q, pos_q);
              n_w = n_w + 2'd1;
              do_fresh = 1'b1;
            end
          end
        end
        M_DOT_NUM: begin
          if (!is_digit(b)) begin
            res_w[n_w] = mk(K_SYMBOL, C_NUMBER, KW_NONE, E_NONE, start_q, dot_q);
            n_w = n_w + 2'd1;
            res_w[n_w] = mk(K_DOT, C_NONE, KW_NONE, E_NONE, dot_q, pos_q); n_w = n_w + 2'd1;
            do_fresh = 1'b1;
          end
        end
        M_DOT_WAIT: begin
          if (!is_digit(b)) begin
            res_w[n_w] = mk(K_DOT, C_NONE, KW_NONE, E_NONE, start_q, pos_q);
            n_w = n_w + 2'd1;
            do_fresh = 1'b1;
          end
        end
        M_OP_WAIT: begin
          if (!(pend_q == "/" && (b == "/" || b == "*"))) begin
            if (k2 != K_EOF) begin
              res_w[n_w] = mk(k2, C_NONE, KW_NONE, E_NONE, start_q, pos_inc);
              n_w = n_w + 2'd1;
            end else begin
              res_w[n_w] = mk(op_one(pend_q), C_NONE, KW_NONE, E_NONE, start_q, pos_q);
              n_w = n_w + 2'd1;
              do_fresh = 1'b1;
            end
          end
        end
        M_STRING: begin
          if (b == "\"") begin
            res_w[n_w] = mk(K_SYMBOL, C_STRING, KW_NONE, E_NONE, start_q, pos_inc);
            n_w = n_w + 2'd1;
          end
        end
        M_LINE, M_BLOCK, M_BLOCK_STAR: ;
        default: do_fresh = 1'b1;
      endcase
      if (do_fresh && fr.emit) begin
        res_w[n_w] = mk(fr.kind, C_NONE, KW_NONE, fr.err, pos_q, pos_inc);
        n_w = n_w + 2'd1;
      end
    end
    if (n_w != 2'd0) res_w[n_w - 2'd1].last = 1'b1;
  end

  // Next scanner state
  always_comb begin
    logic go_fresh;
    go_fresh = 1'b0;
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    dot_d    = dot_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    pend_d   = pend_q;
    if (end_flag_i) begin
      mode_d   = M_IDLE;
      pos_d    = '0;
      start_d  = '0;
      dot_d    = '0;
      prefix_d = '0;
      wlen_d   = '0;
      pend_d   = '0;
    end else begin
      pos_d = pos_inc;
      case (mode_q)
        M_IDENT: begin
          if (is_word(b)) begin
            if (wlen_q < 4'd8) prefix_d = prefix_q | (64'(b) << {wlen_q[2:0], 3'b000});
            if (wlen_q < 4'd9) wlen_d = wlen_q + 4'd1;
          end else begin
            go_fresh = 1'b1;
          end
        end
        M_ZERO, M_INT, M_FRAC, M_HEX, M_BIN, M_OCT: begin
          if (num_ends(mode_q, b)) begin
            if (is_suffix(b)) mode_d = M_IDLE;
            else go_fresh = 1'b1;
          end else if (mode_q == M_ZERO && (b == "x" || b == "X")) begin
            mode_d = M_HEX;
          end else if (mode_q == M_ZERO && (b == "b" || b == "B")) begin
            mode_d = M_BIN;
          end else if (mode_q == M_ZERO && (b == "o" || b == "O")) begin
            mode_d = M_OCT;
          end else if ((mode_q == M_ZERO || mode_q == M_INT) && b == ".") begin
            mode_d = M_DOT_NUM;
            dot_d  = pos_q;
          end else if (mode_q == M_ZERO) begin
            mode_d = M_INT;
          end
        end
        M_DOT_NUM, M_DOT_WAIT: begin
          if (is_digit(b)) mode_d = M_FRAC;
          else go_fresh = 1'b1;
        end
        M_OP_WAIT: begin
          if (pend_q == "/" && b == "/") mode_d = M_LINE;
          else if (pend_q == "/" && b == "*") mode_d = M_BLOCK;
          else if (op_two(pend_q, b) != K_EOF) mode_d = M_IDLE;
          else go_fresh = 1'b1;
        end
        M_LINE: begin
          if (b == 8'h0A) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (b == "*") mode_d = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (b == "/") mode_d = M_IDLE;
          else if (b != "*") mode_d = M_BLOCK;
        end
        M_STRING: begin
          if (b == "\"") mode_d = M_IDLE;
        end
        default: go_fresh = 1'b1;
      endcase
      if (go_fresh) begin
        mode_d  = fr.mode;
        start_d = pos_q;
        if (fr.mode == M_IDENT) begin
          prefix_d = 64'(b);
          wlen_d   = 4'd1;
        end
        if (fr.mode == M_OP_WAIT) pend_d = b;
      end
    end
  end

  // Scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      dot_q    <= '0;
      prefix_q <= '0;
      wlen_q   <= '0;
      pend_q   <= '0;
    end else if (in_take) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      dot_q    <= dot_d;
      prefix_q <= prefix_d;
      wlen_q   <= wlen_d;
      pend_q   <= pend_d;
    end
  end

  // Result buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_take) begin
      cnt_q <= n_w;
    end else if (out_take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result buffer payload: load on a request, shift down as results leave
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      buf_q <= res_w;
    end else if (out_take) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  assign out_valid_o     = (cnt_q != 2'd0);
  assign token_kind_o    = buf_q[0].kind;
  assign symbol_class_o  = buf_q[0].cls;
  assign keyword_index_o = buf_q[0].kw;
  assign error_code_o    = buf_q[0].err;
  assign span_offset_o   = buf_q[0].off;
  assign span_length_o   = buf_q[0].len;
  assign last_of_run_o   = buf_q[0].last;

endmodule
